### rtl/scms_pkg.sv
// ----------------------------------------------------------------------------
// scms_pkg: shared conv / max-pool / SGD step package
// Sizes, codes, controller steps and the tanh and logistic lookup tables.
// ----------------------------------------------------------------------------
package scms_pkg;

   localparam int TAPS          = 3;
   localparam int MAX_LENGTH    = 128;
   localparam int TABLE_ENTRIES = 256;
   localparam int TBL_BITS      = $clog2(TABLE_ENTRIES);
   localparam int CNT_W         = $clog2(MAX_LENGTH + 1);
   localparam int POS_W         = 7;
   localparam int CSR_IDX_W     = 3;

   localparam logic [63:0] EXP_M1_Q32 = 64'd1580030169;
   localparam logic [15:0] LR_RESET   = 16'd3277;

   typedef enum logic [1:0] {
      OP_TRAIN = 2'd0,
      OP_EVAL  = 2'd1,
      OP_LOAD  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WEIGHT_0 = 3'd0,
      CSR_WEIGHT_1 = 3'd1,
      CSR_WEIGHT_2 = 3'd2,
      CSR_SCALE    = 3'd3,
      CSR_LR       = 3'd4
   } csr_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DEC, ST_E0, ST_E1, ST_E2, ST_E3, ST_E4,
      ST_R0, ST_R1, ST_R2, ST_EMIT,
      ST_T0, ST_T1, ST_T2, ST_T3, ST_T4, ST_T5, ST_T6, ST_T7, ST_T8, ST_T9,
      ST_T10, ST_T11, ST_LOAD, ST_CLR
   } st_type;

   typedef struct packed {
      st_type step;
      logic   accept;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   last;
      logic   win_ok;
      logic   rsp_free;
   } stat_type;

   typedef logic signed [15:0] tanh_tbl_type [TABLE_ENTRIES];
   typedef logic        [15:0] logi_tbl_type [TABLE_ENTRIES];

   function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q;
      logic [64:0] r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[63:0], num[i]};
         if (r >= {1'b0, den}) begin
            r    = r - {1'b0, den};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [63:0] exp_neg(input logic [31:0] a);
      logic [63:0]        term;
      logic [63:0]        f;
      logic [63:0]        r;
      logic signed [64:0] sum;
      logic [15:0]        n;
      n    = a[31:16];
      f    = {32'd0, a[15:0], 16'd0};
      term = 64'd1 << 32;
      sum  = $signed({33'd1, 32'd0});
      for (int k = 1; k <= 12; k++) begin
         term = udiv((term * f) >> 32, 64'(k));
         if ((k & 1) != 0) begin
            sum = sum - $signed({1'b0, term});
         end else begin
            sum = sum + $signed({1'b0, term});
         end
      end
      if (sum < 0) begin
         sum = '0;
      end
      r = sum[63:0];
      for (int j = 0; j < 32; j++) begin
         if (j < int'(n)) begin
            r = (r * EXP_M1_Q32) >> 32;
         end
      end
      return r;
   endfunction

   function automatic longint bin_mid(input int i);
      return ((longint'(2 * i + 1)) * (longint'(1) << 19)) / TABLE_ENTRIES
             - (longint'(1) << 19);
   endfunction

   function automatic tanh_tbl_type make_tanh();
      tanh_tbl_type t;
      longint       m;
      longint       am;
      logic [63:0]  e;
      logic [63:0]  den;
      logic [63:0]  q;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         m   = bin_mid(i);
         am  = (m < 0) ? -m : m;
         e   = exp_neg(32'(2 * am));
         den = (64'd1 << 32) + e;
         q   = udiv((((64'd1 << 32) - e) << 15) + (den >> 1), den);
         if (q > 64'd32767) begin
            q = 64'd32767;
         end
         t[i] = (m < 0) ? -$signed(q[15:0]) : $signed(q[15:0]);
      end
      return t;
   endfunction

   function automatic logi_tbl_type make_logistic();
      logi_tbl_type t;
      longint       m;
      longint       am;
      logic [63:0]  e;
      logic [63:0]  den;
      logic [63:0]  q;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         m   = bin_mid(i);
         am  = (m < 0) ? -m : m;
         e   = exp_neg(32'(am));
         den = (64'd1 << 32) + e;
         if (m >= 0) begin
            q = udiv((64'd1 << 47) + (den >> 1), den);
         end else begin
            q = udiv((e << 15) + (den >> 1), den);
         end
         t[i] = q[15:0];
      end
      return t;
   endfunction

   localparam tanh_tbl_type TANH_TBL = make_tanh();
   localparam logi_tbl_type LOGI_TBL = make_logistic();

endpackage

### rtl/scms_req_if.sv
// ----------------------------------------------------------------------------
// scms_req_if: sample word channel
// Valid/ready channel carrying one sample element and its op.
// ----------------------------------------------------------------------------
interface scms_req_if;
   logic                valid;
   logic                ready;
   scms_pkg::op_type    op;
   logic signed [15:0]  sample_value;
   logic                label;
   logic                last;

   modport source (output valid, op, sample_value, label, last, input ready);
   modport sink   (input valid, op, sample_value, label, last, output ready);
endinterface

### rtl/scms_rsp_if.sv
// ----------------------------------------------------------------------------
// scms_rsp_if: result word channel
// Valid/ready channel carrying one classification result.
// ----------------------------------------------------------------------------
interface scms_rsp_if;
   logic        valid;
   logic        ready;
   logic        predicted;
   logic [15:0] probability;
   logic [6:0]  best_position;
   logic        correct;

   modport source (output valid, predicted, probability, best_position, correct,
                   input ready);
   modport sink   (input valid, predicted, probability, best_position, correct,
                   output ready);
endinterface

### rtl/scms_ctrl.sv
// ----------------------------------------------------------------------------
// scms_ctrl: step sequencer
// Walks MAC and pool steps per word, then readout and, for training, update.
// ----------------------------------------------------------------------------
module scms_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  scms_pkg::stat_type stat,
   output scms_pkg::cmd_type  cmd
);
   import scms_pkg::*;

   st_type state_ff;
   st_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd.step   = state_ff;
      cmd.accept = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DEC;
         end
         ST_DEC: begin
            unique case (stat.op)
               OP_LOAD: state_in = ST_LOAD;
               OP_NONE: state_in = ST_IDLE;
               default: state_in = stat.win_ok ? ST_E0 : ST_E4;
            endcase
         end
         ST_E0:  state_in = ST_E1;
         ST_E1:  state_in = ST_E2;
         ST_E2:  state_in = ST_E3;
         ST_E3:  state_in = ST_E4;
         ST_E4:  state_in = stat.last ? ST_R0 : ST_IDLE;
         ST_R0:  state_in = ST_R1;
         ST_R1:  state_in = ST_R2;
         ST_R2:  state_in = ST_EMIT;
         ST_EMIT: begin
            if (stat.rsp_free) state_in = (stat.op == OP_TRAIN) ? ST_T0 : ST_CLR;
         end
         ST_T0:  state_in = ST_T1;
         ST_T1:  state_in = ST_T2;
         ST_T2:  state_in = ST_T3;
         ST_T3:  state_in = ST_T4;
         ST_T4:  state_in = ST_T5;
         ST_T5:  state_in = ST_T6;
         ST_T6:  state_in = ST_T7;
         ST_T7:  state_in = ST_T8;
         ST_T8:  state_in = ST_T9;
         ST_T9:  state_in = ST_T10;
         ST_T10: state_in = ST_T11;
         ST_T11: state_in = ST_CLR;
         ST_LOAD: state_in = ST_IDLE;
         ST_CLR:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   ap_train_after_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_T0) |-> ($past(state_ff) == ST_EMIT && stat.op == OP_TRAIN))
      else $error("update started without a result");
   ap_readout_after_pool: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_R0) |-> ($past(state_ff) == ST_E4 && stat.last))
      else $error("readout started before the last word");
   ap_mac_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_E0) |-> stat.win_ok)
      else $error("MAC started without a full window");

endmodule

### rtl/scms_dp.sv
// ----------------------------------------------------------------------------
// scms_dp: filter, pooling, readout and SGD datapath
// One shared multiplier, the model registers, lookup tables and result register.
// ----------------------------------------------------------------------------
module scms_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  scms_pkg::cmd_type            cmd,
   output scms_pkg::stat_type           stat,
   input  logic                         req_valid,
   input  scms_pkg::op_type             req_op,
   input  logic signed [15:0]           req_sample_value,
   input  logic                         req_label,
   input  logic                         req_last,
   input  logic                         csr_write_enable,
   input  logic [scms_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                  csr_write_data,
   scms_rsp_if.source                   rsp
);
   import scms_pkg::*;

   logic signed [31:0] init_w_ff [TAPS];
   logic signed [31:0] init_scale_ff;
   logic        [15:0] lr_ff;

   logic signed [31:0] w_ff [TAPS];
   logic signed [31:0] fb_ff;
   logic signed [31:0] scale_ff;
   logic signed [31:0] rb_ff;

   logic signed [15:0] rv_ff [TAPS-1];
   logic signed [15:0] bw_ff [TAPS];
   logic signed [15:0] best_ff;
   logic [POS_W-1:0]   bidx_ff;
   logic [CNT_W-1:0]   cnt_ff;

   op_type             op_ff;
   logic signed [15:0] x_ff;
   logic               label_ff;
   logic               last_ff;

   logic signed [32:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [50:0] prod_in;
   logic signed [50:0] prod_ff;
   logic signed [48:0] acc_ff;
   logic signed [48:0] acc_sum;
   logic signed [39:0] z_ff;
   logic [15:0]        prob_ff;
   logic signed [15:0] dout_ff;
   logic [15:0]        h_ff;
   logic signed [31:0] dpre_ff;
   logic signed [31:0] lrd_ff;
   logic signed [31:0] step_ff;

   logic signed [50:0] sh12;
   logic signed [50:0] sh15;
   logic signed [50:0] sh16;
   logic signed [50:0] sh30;
   logic [TBL_BITS-1:0] tbl_idx;
   logic signed [15:0] act;
   logic [30:0]        h_diff;
   logic signed [16:0] o_minus_y;
   logic               accept;
   logic               rsp_free;
   logic               pred;

   function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [50:0] b);
      logic signed [51:0] d;
      d = {{20{a[31]}}, a} - {b[50], b};
      if (d > 52'sh7FFFFFFF) begin
         return 32'sh7FFFFFFF;
      end else if (d < -52'sh80000000) begin
         return 32'sh80000000;
      end
      return d[31:0];
   endfunction

   assign accept   = req_valid && cmd.accept;
   assign rsp_free = !rsp.valid || rsp.ready;
   assign prod_in  = mul_a * mul_b;
   assign sh12     = prod_ff >>> 12;
   assign sh15     = prod_ff >>> 15;
   assign sh16     = prod_ff >>> 16;
   assign sh30     = prod_ff >>> 30;
   assign acc_sum  = acc_ff + prod_ff[48:0];
   assign h_diff   = 31'h40000000 - prod_ff[30:0];
   assign o_minus_y = $signed({1'b0, prob_ff}) - (label_ff ? 17'sd32768 : 17'sd0);
   assign pred     = (prob_ff > 16'd16384);

   always_comb begin
      if (z_ff < -40'sd524288) begin
         tbl_idx = '0;
      end else if (z_ff > 40'sd524287) begin
         tbl_idx = '1;
      end else begin
         tbl_idx = {~z_ff[19], z_ff[18:20-TBL_BITS]};
      end
   end
   assign act = TANH_TBL[tbl_idx];

   assign stat.op       = op_ff;
   assign stat.last     = last_ff;
   assign stat.win_ok   = (cnt_ff >= CNT_W'(TAPS - 1)) && (cnt_ff < CNT_W'(MAX_LENGTH));
   assign stat.rsp_free = rsp_free;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.step)
         ST_E0:  begin mul_a = 33'(w_ff[0]);  mul_b = 18'(rv_ff[0]); end
         ST_E1:  begin mul_a = 33'(w_ff[1]);  mul_b = 18'(rv_ff[1]); end
         ST_E2:  begin mul_a = 33'(w_ff[2]);  mul_b = 18'(x_ff);     end
         ST_R0:  begin mul_a = 33'(scale_ff); mul_b = 18'(best_ff);  end
         ST_T0: begin
            mul_a = $signed({17'd0, prob_ff});
            mul_b = $signed({2'b00, 16'h8000 - prob_ff});
         end
         ST_T1: begin
            mul_a = 33'(o_minus_y);
            mul_b = $signed({1'b0, prod_ff[31:15]});
         end
         ST_T2:  begin mul_a = 33'(best_ff);  mul_b = 18'(best_ff);  end
         ST_T3:  begin mul_a = 33'(scale_ff); mul_b = 18'(dout_ff);  end
         ST_T4:  begin mul_a = $signed(sh15[32:0]); mul_b = $signed({2'b00, h_ff}); end
         ST_T5:  begin mul_a = 33'(dout_ff);  mul_b = $signed({2'b00, lr_ff}); end
         ST_T6:  begin mul_a = 33'(dpre_ff);  mul_b = $signed({2'b00, lr_ff}); end
         ST_T7:  begin mul_a = 33'(lrd_ff);   mul_b = 18'(best_ff);  end
         ST_T8:  begin mul_a = 33'(step_ff);  mul_b = 18'(bw_ff[0]); end
         ST_T9:  begin mul_a = 33'(step_ff);  mul_b = 18'(bw_ff[1]); end
         ST_T10: begin mul_a = 33'(step_ff);  mul_b = 18'(bw_ff[2]); end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (accept) begin
         op_ff    <= req_op;
         x_ff     <= req_sample_value;
         label_ff <= req_label;
         last_ff  <= req_last;
      end
      case (cmd.step)
         ST_E1: acc_ff  <= prod_ff[48:0];
         ST_E2: acc_ff  <= acc_sum;
         ST_E3: z_ff    <= 40'(fb_ff) + 40'(acc_sum >>> 12);
         ST_R1: z_ff    <= 40'(rb_ff) + 40'(sh15);
         ST_R2: prob_ff <= LOGI_TBL[tbl_idx];
         ST_T2: dout_ff <= prod_ff[30:15];
         ST_T3: h_ff    <= h_diff[30:15];
         ST_T5: dpre_ff <= sh15[31:0];
         ST_T6: lrd_ff  <= prod_ff[31:0];
         ST_T7: step_ff <= sh16[31:0];
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < TAPS; k++) init_w_ff[k] <= '0;
         init_scale_ff <= '0;
         lr_ff         <= LR_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_WEIGHT_0: init_w_ff[0]  <= csr_write_data;
            CSR_WEIGHT_1: init_w_ff[1]  <= csr_write_data;
            CSR_WEIGHT_2: init_w_ff[2]  <= csr_write_data;
            CSR_SCALE:    init_scale_ff <= csr_write_data;
            CSR_LR:       lr_ff         <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < TAPS; k++) w_ff[k] <= '0;
         fb_ff    <= '0;
         scale_ff <= '0;
         rb_ff    <= '0;
      end else begin
         case (cmd.step)
            ST_LOAD: begin
               for (int k = 0; k < TAPS; k++) w_ff[k] <= init_w_ff[k];
               scale_ff <= init_scale_ff;
               fb_ff    <= '0;
               rb_ff    <= '0;
            end
            ST_T6:  rb_ff    <= sat_sub(rb_ff, sh15);
            ST_T7:  fb_ff    <= sat_sub(fb_ff, sh16);
            ST_T8:  scale_ff <= sat_sub(scale_ff, sh30);
            ST_T9:  w_ff[0]  <= sat_sub(w_ff[0], sh12);
            ST_T10: w_ff[1]  <= sat_sub(w_ff[1], sh12);
            ST_T11: w_ff[2]  <= sat_sub(w_ff[2], sh12);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.step == ST_LOAD || cmd.step == ST_CLR) begin
         for (int k = 0; k < TAPS - 1; k++) rv_ff[k] <= '0;
         for (int k = 0; k < TAPS; k++) bw_ff[k] <= '0;
         best_ff <= 16'sh8000;
         bidx_ff <= '0;
         cnt_ff  <= '0;
      end else if (cmd.step == ST_E4) begin
         if (stat.win_ok && act > best_ff) begin
            best_ff  <= act;
            bidx_ff  <= POS_W'(cnt_ff - CNT_W'(TAPS - 1));
            bw_ff[0] <= rv_ff[0];
            bw_ff[1] <= rv_ff[1];
            bw_ff[2] <= x_ff;
         end
         rv_ff[0] <= rv_ff[1];
         rv_ff[1] <= x_ff;
         if (cnt_ff < CNT_W'(MAX_LENGTH)) cnt_ff <= cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp.valid <= 1'b0;
      end else if (cmd.step == ST_EMIT && rsp_free) begin
         rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
         rsp.valid <= 1'b0;
      end
      if (cmd.step == ST_EMIT && rsp_free) begin
         rsp.predicted     <= pred;
         rsp.probability   <= prob_ff;
         rsp.best_position <= bidx_ff;
         rsp.correct       <= (pred == label_ff);
      end
   end

   ap_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) |-> ($past(cmd.step) == ST_EMIT))
      else $error("result word without readout");
   ap_prob_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.probability <= 16'd32768))
      else $error("probability out of range");
   ap_count_sat: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_LENGTH))
      else $error("element count past limit");
   ap_clear_after_emit: assert property (@(posedge clock) disable iff (reset)
      ($past(cmd.step) == ST_CLR) |-> (cnt_ff == '0 && best_ff == 16'sh8000))
      else $error("sample state not cleared");

endmodule

### rtl/shared_conv_maxpool_sgd_step.sv
// ----------------------------------------------------------------------------
// shared_conv_maxpool_sgd_step: three-tap filter, max pool, logistic, SGD
// Classifies each sample and optionally trains the shared weights on it.
//
//   channel  dir  width  word
//   req_port in   20     op, sample_value, label, last
//   rsp_port out  25     predicted, probability, best_position, correct
//   csr_*    in   36     write enable, index, data
//
// An element with a full window walks decode, three MACs on the shared
// multiplier, sum and pool; one without a window goes from decode to pool.
// The last element adds the readout steps and one clear; training adds the
// update steps, which run in order since each waits on the previous product.
// Synchronous reset clears control, CSRs, model, sample state and rsp.valid.
// A held result blocks only the next readout; the output register frees it.
// ----------------------------------------------------------------------------
module shared_conv_maxpool_sgd_step (
   input  logic                           clock,
   input  logic                           reset,
   scms_req_if.sink                       req_port,
   scms_rsp_if.source                     rsp_port,
   input  logic                           csr_write_enable,
   input  logic [scms_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                    csr_write_data
);
   import scms_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign req_port.ready = cmd.accept;

   scms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   scms_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_valid        (req_port.valid),
      .req_op           (req_port.op),
      .req_sample_value (req_port.sample_value),
      .req_label        (req_port.label),
      .req_last         (req_port.last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp              (rsp_port)
   );

endmodule
